// File: src/srr_pkg.sv
// Shared constants, configuration register indexes and controller/datapath
// command and status types for the stepper speed ramp regulator.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package srr_pkg;

  // Default geometry of the speed distance and its square root.
  localparam int unsigned DISTANCE_BITS_DEF = 32;
  localparam int unsigned ROOT_BITS_DEF     = 16;

  // Fixed widths of the channel fields.
  localparam int unsigned DIST_PORT_W = 32;
  localparam int unsigned ROOT_PORT_W = 16;
  localparam int unsigned DELAY_W     = 32;
  localparam int unsigned STEP_W      = 8;

  // Largest decrease of the speed distance per deceleration jump.
  localparam int unsigned JUMP_W   = 16;
  localparam int unsigned JUMP_MAX = 65535;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP    = 2'd2;

  localparam logic [STEP_W-1:0] RAMP_STEP_RST = 8'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take the input beat and apply the new-move flag
    logic decide;     // apply the regulation rule and set up the root walk
    logic walk;       // one step of the root walk
    logic div_start;  // start recomputing the step delay from the root
    logic div_step;   // one quotient bit
    logic publish;    // load the output register
  } srr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic root_moved;
    logic div_done;
  } srr_status_t;

endpackage

// File: src/srr_if.sv
// Valid/ready channel interfaces for the stepper speed ramp regulator:
// one carries the tick input, the other the per-tick result.
// Depends on srr_pkg for the field widths.
`timescale 1ns / 1ps

interface srr_in_if;
  logic                             valid;
  logic                             ready;
  logic [srr_pkg::DIST_PORT_W-1:0]  remaining_distance;
  logic                             new_move;

  modport source (output valid, output remaining_distance, output new_move, input ready);
  modport sink   (input valid, input remaining_distance, input new_move, output ready);
endinterface

interface srr_out_if;
  logic                             valid;
  logic                             ready;
  logic [srr_pkg::DIST_PORT_W-1:0]  ramp_distance;
  logic [srr_pkg::ROOT_PORT_W-1:0]  ramp_root;
  logic [srr_pkg::DELAY_W-1:0]      step_delay;
  logic                             delay_changed;
  logic                             speed_reached;

  modport source (output valid, output ramp_distance, output ramp_root, output step_delay,
                  output delay_changed, output speed_reached, input ready);
  modport sink   (input valid, input ramp_distance, input ramp_root, input step_delay,
                  input delay_changed, input speed_reached, output ready);
endinterface

// File: src/srr_ctrl.sv
// Sequencer of the stepper speed ramp regulator: steps one tick through
// decision, root walk, delay division and output, and owns the output valid.
// Depends on srr_pkg for the command and status types.
`timescale 1ns / 1ps

module srr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  srr_pkg::srr_status_t status_i,
  output srr_pkg::srr_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_done) begin
          if (status_i.root_moved) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // The output register is free once its beat has gone or goes now.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on publish, cleared when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/srr_datapath.sv
// Datapath of the stepper speed ramp regulator: configuration registers,
// speed distance with its incrementally walked square root, a bit-serial
// delay divider and the output register. Depends on srr_pkg.
`timescale 1ns / 1ps

module srr_datapath #(
  parameter int unsigned DISTANCE_BITS = srr_pkg::DISTANCE_BITS_DEF,
  parameter int unsigned ROOT_BITS     = srr_pkg::ROOT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srr_pkg::srr_cmd_t                 cmd_i,
  output srr_pkg::srr_status_t              status_o,
  input  logic                              cfg_we_i,
  input  logic [srr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [srr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [srr_pkg::DIST_PORT_W-1:0]   remaining_distance_i,
  input  logic                              new_move_i,
  output logic [srr_pkg::DIST_PORT_W-1:0]   ramp_distance_o,
  output logic [srr_pkg::ROOT_PORT_W-1:0]   ramp_root_o,
  output logic [srr_pkg::DELAY_W-1:0]       step_delay_o,
  output logic                              delay_changed_o,
  output logic                              speed_reached_o
);

  localparam int unsigned DistW   = DISTANCE_BITS;
  localparam int unsigned RootW   = ROOT_BITS;
  localparam int unsigned GapW    = ROOT_BITS + 1;
  localparam int unsigned KW      = (DistW < srr_pkg::JUMP_W) ? DistW : srr_pkg::JUMP_W;
  localparam int unsigned CW      = (GapW > KW) ? GapW : KW;
  localparam int unsigned CapBits = (2 * RootW < DistW) ? 2 * RootW : DistW;
  localparam int unsigned DelayW  = srr_pkg::DELAY_W;
  localparam int unsigned DivCntW = $clog2(DelayW + 1);

  // Largest distance whose root fits the root register.
  localparam logic [DistW-1:0] DistLimit = {DistW{1'b1}} >> (DistW - CapBits);
  localparam logic [DistW-1:0] JumpLimit = DistW'(srr_pkg::JUMP_MAX);

  // Configuration registers.
  logic [DelayW-1:0]         target_q;
  logic [DelayW-1:0]         scale_q;
  logic [srr_pkg::STEP_W-1:0] step_q;

  // Regulation state.
  logic [DistW-1:0]  dist_q, dist_d;
  logic [RootW-1:0]  root_q, root_d;
  logic [GapW-1:0]   lower_q, lower_d;
  logic [GapW-1:0]   upper_q, upper_d;
  logic [GapW-1:0]   odd_q, odd_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic              accel_q, accel_d;
  logic              armed_q, armed_d;
  logic              not_reached_q, not_reached_d;

  // Per-tick working registers.
  logic [srr_pkg::DIST_PORT_W-1:0] rem_q, rem_d;
  logic [RootW-1:0]  root_before_q, root_before_d;
  logic [KW-1:0]     walk_k_q, walk_k_d;
  logic              walk_down_q, walk_down_d;
  logic              walk_busy_q, walk_busy_d;
  logic [RootW-1:0]  div_rem_q, div_rem_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;

  // Regulation decode.
  logic             jump;
  logic [DistW-1:0] diff;
  logic [DistW-1:0] diff_clamp;
  logic [DistW-1:0] step_dist;
  logic [DistW-1:0] room;
  logic [DistW-1:0] raise_amt;
  logic [DistW-1:0] lower_amt;
  logic             do_raise;
  logic             do_lower;

  // Walk and divide helpers.
  logic [CW-1:0]    k_x;
  logic [CW-1:0]    upper_x;
  logic [CW-1:0]    lower_x;
  logic [RootW:0]   div_shift;
  logic             div_ge;
  logic             root_moved;

  assign root_moved = (root_q != root_before_q);

  assign status_o.walk_done  = !walk_busy_q;
  assign status_o.root_moved = root_moved;
  assign status_o.div_done   = (div_cnt_q == '0);

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      scale_q  <= '0;
      step_q   <= srr_pkg::RAMP_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        srr_pkg::CFG_TARGET_DELAY: target_q <= cfg_data_i;
        srr_pkg::CFG_DELAY_SCALE:  scale_q  <= cfg_data_i;
        srr_pkg::CFG_RAMP_STEP:    step_q   <= cfg_data_i[srr_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Jump, raise and lower amounts for the decision cycle.
  always_comb begin
    jump       = (rem_q < srr_pkg::DIST_PORT_W'(dist_q));
    diff       = dist_q - DistW'(rem_q);
    diff_clamp = (diff > JumpLimit) ? JumpLimit : diff;
    step_dist  = DistW'(step_q);
    room       = DistLimit - dist_q;
    raise_amt  = (step_dist > room) ? room : step_dist;
    lower_amt  = jump ? diff_clamp : step_dist;
  end

  // Operands of one walk step and one divide step.
  always_comb begin
    k_x       = CW'(walk_k_q);
    upper_x   = CW'(upper_q);
    lower_x   = CW'(lower_q);
    div_shift = {div_rem_q, delay_q[DelayW-1]};
    div_ge    = (div_shift >= {1'b0, root_q});
  end

  // Next state of the datapath.
  always_comb begin
    dist_d        = dist_q;
    root_d        = root_q;
    lower_d       = lower_q;
    upper_d       = upper_q;
    odd_d         = odd_q;
    delay_d       = delay_q;
    accel_d       = accel_q;
    armed_d       = armed_q;
    not_reached_d = not_reached_q;
    rem_d         = rem_q;
    root_before_d = root_before_q;
    walk_k_d      = walk_k_q;
    walk_down_d   = walk_down_q;
    walk_busy_d   = walk_busy_q;
    div_rem_d     = div_rem_q;
    div_cnt_d     = div_cnt_q;
    do_raise      = 1'b0;
    do_lower      = 1'b0;

    if (cmd_i.load) begin
      // A new move re-arms regulation and loads the delay when stopped.
      rem_d         = remaining_distance_i;
      root_before_d = root_q;
      if (new_move_i) begin
        not_reached_d = 1'b1;
        if (dist_q == '0) begin
          delay_d = scale_q;
        end
      end
    end

    if (cmd_i.decide) begin
      if (jump) begin
        do_lower      = 1'b1;
        not_reached_d = 1'b1;
        armed_d       = 1'b0;
      end else if (not_reached_q) begin
        if (delay_q > target_q) begin
          if (!accel_q && armed_q) begin
            delay_d       = target_q;
            not_reached_d = 1'b0;
          end else begin
            do_raise = 1'b1;
            accel_d  = 1'b1;
            armed_d  = 1'b1;
          end
        end else if (delay_q < target_q) begin
          if (accel_q && armed_q) begin
            delay_d       = target_q;
            not_reached_d = 1'b0;
          end else begin
            do_lower = 1'b1;
            accel_d  = 1'b0;
            armed_d  = 1'b1;
          end
        end
      end

      if (do_raise) begin
        dist_d      = dist_q + raise_amt;
        walk_k_d    = KW'(raise_amt);
        walk_down_d = 1'b0;
        walk_busy_d = 1'b1;
      end else if (do_lower) begin
        if (lower_amt >= dist_q) begin
          // Lowering to or past zero clears distance and root at once.
          dist_d  = '0;
          root_d  = '0;
          lower_d = GapW'(1);
          upper_d = GapW'(1);
          odd_d   = GapW'(1);
        end else begin
          dist_d      = dist_q - lower_amt;
          walk_k_d    = KW'(lower_amt);
          walk_down_d = 1'b1;
          walk_busy_d = 1'b1;
        end
      end
    end

    // One step of the root walk across the odd-number bounds.
    if (cmd_i.walk && walk_busy_q) begin
      if (!walk_down_q) begin
        if (upper_x <= k_x) begin
          walk_k_d = KW'(k_x - upper_x);
          root_d   = root_q + RootW'(1);
          odd_d    = odd_q + GapW'(2);
          lower_d  = GapW'(1);
          upper_d  = odd_q + GapW'(2);
        end else begin
          upper_d     = GapW'(upper_x - k_x);
          lower_d     = GapW'(lower_x + k_x);
          walk_busy_d = 1'b0;
        end
      end else begin
        if ((lower_x <= k_x) && (root_q != '0)) begin
          walk_k_d = KW'(k_x - lower_x);
          root_d   = root_q - RootW'(1);
          odd_d    = odd_q - GapW'(2);
          lower_d  = odd_q - GapW'(2);
          upper_d  = GapW'(1);
        end else begin
          upper_d     = GapW'(upper_x + k_x);
          lower_d     = GapW'(lower_x - k_x);
          walk_busy_d = 1'b0;
        end
      end
    end

    // Delay recompute: a zero root takes the scale as it is.
    if (cmd_i.div_start) begin
      delay_d   = scale_q;
      div_rem_d = '0;
      div_cnt_d = (root_q == '0) ? '0 : DivCntW'(DelayW);
    end

    // Restoring division, one quotient bit per cycle shifted into the delay.
    if (cmd_i.div_step && (div_cnt_q != '0)) begin
      div_rem_d = div_ge ? RootW'(div_shift - {1'b0, root_q}) : RootW'(div_shift);
      delay_d   = {delay_q[DelayW-2:0], div_ge};
      div_cnt_d = div_cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q        <= '0;
      root_q        <= '0;
      lower_q       <= GapW'(1);
      upper_q       <= GapW'(1);
      odd_q         <= GapW'(1);
      delay_q       <= '0;
      accel_q       <= 1'b1;
      armed_q       <= 1'b0;
      not_reached_q <= 1'b0;
      walk_busy_q   <= 1'b0;
      div_cnt_q     <= '0;
    end else begin
      dist_q        <= dist_d;
      root_q        <= root_d;
      lower_q       <= lower_d;
      upper_q       <= upper_d;
      odd_q         <= odd_d;
      delay_q       <= delay_d;
      accel_q       <= accel_d;
      armed_q       <= armed_d;
      not_reached_q <= not_reached_d;
      walk_busy_q   <= walk_busy_d;
      div_cnt_q     <= div_cnt_d;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk_i) begin
    rem_q         <= rem_d;
    root_before_q <= root_before_d;
    walk_k_q      <= walk_k_d;
    walk_down_q   <= walk_down_d;
    div_rem_q     <= div_rem_d;
  end

  // Output register, loaded when the controller publishes a result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      ramp_distance_o <= srr_pkg::DIST_PORT_W'(dist_q);
      ramp_root_o     <= srr_pkg::ROOT_PORT_W'(root_q);
      step_delay_o    <= delay_q;
      delay_changed_o <= root_moved;
      speed_reached_o <= !not_reached_q;
    end
  end

endmodule

// File: src/stepper_speed_ramp_regulator.sv
// Top level of the stepper speed ramp regulator: joins the sequencer and the
// datapath to the tick and result channels and the configuration port.
// Depends on srr_pkg, srr_if, srr_ctrl and srr_datapath.
//
// Usage:
//   in_if carries one regulation tick per beat (remaining distance, new-move
//   flag); out_if returns exactly one result beat per tick, in order.
//   Configuration (target delay, delay scale, ramp step) is written through
//   cfg_we_i / cfg_index_i / cfg_data_i while no tick is in flight.
//   One tick is handled at a time. After the input beat the sequencer loads the
//   tick and decides, walks the root when the distance moves (one step per
//   crossed square bound plus one more that settles it), runs the delay divider
//   when the root changes to a nonzero value (one quotient bit per cycle) or
//   takes the scale as it is when the root drops to zero, and then loads the
//   output register. The sequencer is ready for the next tick in the cycle
//   after a result is loaded, so a tick is never taken before the last one is
//   loaded; the walk and the divider set the tick rate.
//   The output register holds a finished result while the receiver stalls;
//   the next tick is still taken and worked on, and waits in its last state
//   until the output register frees.
//   Reset clears distance, root and delay, loads ramp step 1, and leaves no
//   result pending.
`timescale 1ns / 1ps

module stepper_speed_ramp_regulator #(
  parameter int unsigned DISTANCE_BITS = srr_pkg::DISTANCE_BITS_DEF,
  parameter int unsigned ROOT_BITS     = srr_pkg::ROOT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  srr_in_if.sink                         in_if,
  srr_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [srr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [srr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  srr_pkg::srr_cmd_t    cmd;
  srr_pkg::srr_status_t status;

  // Sequencer.
  srr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath.
  srr_datapath #(
    .DISTANCE_BITS (DISTANCE_BITS),
    .ROOT_BITS     (ROOT_BITS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .remaining_distance_i (in_if.remaining_distance),
    .new_move_i           (in_if.new_move),
    .ramp_distance_o      (out_if.ramp_distance),
    .ramp_root_o          (out_if.ramp_root),
    .step_delay_o         (out_if.step_delay),
    .delay_changed_o      (out_if.delay_changed),
    .speed_reached_o      (out_if.speed_reached)
  );

endmodule

// File: src/srr_checker.sv
// Port-level checker for the stepper speed ramp regulator and the bind that
// attaches it to the top level. Depends on srr_pkg and the top level.
`timescale 1ns / 1ps

module srr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [srr_pkg::DIST_PORT_W-1:0]   ramp_distance_i,
  input logic [srr_pkg::ROOT_PORT_W-1:0]   ramp_root_i,
  input logic [srr_pkg::DELAY_W-1:0]       step_delay_i,
  input logic                              delay_changed_i,
  input logic                              cfg_we_i,
  input logic [srr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input logic [srr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic        in_beat;
  logic        out_beat;
  logic [1:0]  flight_q, flight_d;
  logic [31:0] scale_q;
  logic [33:0] root_sq;
  logic [33:0] next_sq;
  logic [47:0] delay_prod;
  logic        root_ok;
  logic        delay_ok;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Ticks taken whose result beat has not gone yet.
  always_comb begin
    flight_d = flight_q + 2'(in_beat) - 2'(out_beat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
      scale_q  <= '0;
    end else begin
      flight_q <= flight_d;
      if (cfg_we_i && (cfg_index_i == srr_pkg::CFG_DELAY_SCALE)) begin
        scale_q <= cfg_data_i;
      end
    end
  end

  // Root must be the floor square root; a recomputed delay the floor quotient.
  always_comb begin
    root_sq    = 34'(ramp_root_i) * 34'(ramp_root_i);
    next_sq    = (34'(ramp_root_i) + 34'd1) * (34'(ramp_root_i) + 34'd1);
    delay_prod = 48'(step_delay_i) * 48'(ramp_root_i);
    root_ok    = (root_sq <= 34'(ramp_distance_i)) && (next_sq > 34'(ramp_distance_i));
    if (ramp_root_i == '0) begin
      delay_ok = (step_delay_i == scale_q);
    end else begin
      delay_ok = (delay_prod <= 48'(scale_q)) &&
                 ((48'(scale_q) - delay_prod) < 48'(ramp_root_i));
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(ramp_distance_i))
    else $error("result beat dropped or changed while stalled");

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> root_ok)
    else $error("ramp_root is not the floor square root of ramp_distance");

  a_delay_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && delay_changed_i |-> delay_ok)
    else $error("recomputed step_delay is not delay_scale divided by the root");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> flight_q != 2'd0)
    else $error("result beat without a pending tick");

  a_one_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> flight_q < 2'd2)
    else $error("tick taken while two results are pending");

endmodule

bind stepper_speed_ramp_regulator srr_checker u_srr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .ramp_distance_i (out_if.ramp_distance),
  .ramp_root_i     (out_if.ramp_root),
  .step_delay_i    (out_if.step_delay),
  .delay_changed_i (out_if.delay_changed),
  .cfg_we_i        (cfg_we_i),
  .cfg_index_i     (cfg_index_i),
  .cfg_data_i      (cfg_data_i)
);

// File: bench/tb_stepper_speed_ramp_regulator.sv
// Self-checking bench for the stepper speed ramp regulator: ticks go in through
// a bursty driver and results are checked against a cycle-free predictor of the ramp.
// Depends on srr_pkg, srr_if and the stepper_speed_ramp_regulator top level.
`timescale 1ns / 1ps

module tb_stepper_speed_ramp_regulator;

  localparam int unsigned IDLE_LIMIT = 8000;
  localparam int unsigned LONG_HOLD  = 600;
  localparam int unsigned END_WAIT   = 400;
  localparam logic [srr_pkg::DIST_PORT_W-1:0] DIST_CEIL = '1;

  typedef struct packed {
    logic [srr_pkg::DIST_PORT_W-1:0] remaining;
    logic                            new_move;
  } tick_t;

  typedef struct packed {
    logic [srr_pkg::DIST_PORT_W-1:0] ramp_dist;
    logic [srr_pkg::ROOT_PORT_W-1:0] root;
    logic [srr_pkg::DELAY_W-1:0]     delay;
    logic                            changed;
    logic                            reached;
  } ramp_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                           cfg_we;
  logic [srr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [srr_pkg::CFG_DATA_W-1:0] cfg_data;

  srr_in_if  tick_ch ();
  srr_out_if res_ch ();

  stepper_speed_ramp_regulator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (tick_ch),
    .out_if      (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Configuration copy and ramp state of the predictor.
  logic [srr_pkg::DELAY_W-1:0]     cfg_target = '0;
  logic [srr_pkg::DELAY_W-1:0]     cfg_scale  = '0;
  logic [srr_pkg::STEP_W-1:0]      cfg_step   = srr_pkg::RAMP_STEP_RST;
  logic [srr_pkg::DIST_PORT_W-1:0] speed_dist = '0;
  logic [srr_pkg::ROOT_PORT_W-1:0] speed_root = '0;
  int unsigned                     gap_below  = 1;
  int unsigned                     gap_above  = 1;
  int unsigned                     odd_width  = 1;
  logic [srr_pkg::DELAY_W-1:0]     step_period = '0;
  logic                            was_accel  = 1'b1;
  logic                            overshoot_armed = 1'b0;
  logic                            regulating = 1'b0;

  tick_t        pending_ticks[$];
  ramp_result_t expected_results[$];
  int unsigned  queued_total   = 0;
  int unsigned  accepted_total = 0;
  int unsigned  results_seen   = 0;
  int unsigned  mismatches     = 0;
  logic         tick_fired     = 1'b0;

  function automatic void clear_ramp();
    speed_dist = '0;
    speed_root = '0;
    gap_below  = 1;
    gap_above  = 1;
    odd_width  = 1;
  endfunction

  // Walk the root up past every odd-number bound that the increase crosses.
  function automatic void grow_distance(int unsigned k);
    int unsigned room;
    room = DIST_CEIL - speed_dist;
    if (k > room) k = room;
    speed_dist = speed_dist + k;
    while (gap_above <= k) begin
      k          = k - gap_above;
      speed_root = speed_root + 1'b1;
      odd_width  = odd_width + 2;
      gap_below  = 1;
      gap_above  = odd_width;
    end
    gap_above = gap_above - k;
    gap_below = gap_below + k;
  endfunction

  // Walk the root down; a decrease to or below zero clears the whole ramp.
  function automatic void shrink_distance(int unsigned k);
    if (k >= speed_dist) begin
      clear_ramp();
      return;
    end
    speed_dist = speed_dist - k;
    while (gap_below <= k && speed_root > 0) begin
      k          = k - gap_below;
      speed_root = speed_root - 1'b1;
      odd_width  = odd_width - 2;
      gap_below  = odd_width;
      gap_above  = 1;
    end
    gap_above = gap_above + k;
    gap_below = gap_below - k;
  endfunction

  // One regulation tick: new-move flag first, then jump or ramp, then the delay.
  function automatic ramp_result_t regulate_tick(tick_t t);
    ramp_result_t r;
    logic [srr_pkg::ROOT_PORT_W-1:0] root_prev;
    logic [srr_pkg::DIST_PORT_W-1:0] drop;
    if (t.new_move) begin
      regulating = 1'b1;
      if (speed_dist == 0) step_period = cfg_scale;
    end
    root_prev = speed_root;
    if (t.remaining < speed_dist) begin
      drop = speed_dist - t.remaining;
      if (drop > srr_pkg::JUMP_MAX) drop = srr_pkg::JUMP_MAX;
      shrink_distance(drop);
      regulating      = 1'b1;
      overshoot_armed = 1'b0;
    end else if (regulating) begin
      if (step_period > cfg_target) begin
        if (!was_accel && overshoot_armed) begin
          step_period = cfg_target;
          regulating  = 1'b0;
        end else begin
          grow_distance(cfg_step);
          was_accel       = 1'b1;
          overshoot_armed = 1'b1;
        end
      end else if (step_period < cfg_target) begin
        if (was_accel && overshoot_armed) begin
          step_period = cfg_target;
          regulating  = 1'b0;
        end else begin
          shrink_distance(cfg_step);
          was_accel       = 1'b0;
          overshoot_armed = 1'b1;
        end
      end
    end
    r.changed = (speed_root != root_prev);
    if (r.changed) begin
      step_period = (speed_root != 0) ? cfg_scale / {16'd0, speed_root} : cfg_scale;
    end
    r.ramp_dist = speed_dist;
    r.root      = speed_root;
    r.delay     = step_period;
    r.reached   = !regulating;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h (result %0d)",
             $realtime, what, got, want, results_seen);
    mismatches++;
  endtask

  // Result check first, then prediction for the tick beat taken at this edge.
  always @(posedge clk_i) begin : check_and_predict
    ramp_result_t want;
    tick_t        taken;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, distance", res_ch.ramp_distance, '0);
        end else begin
          want = expected_results.pop_front();
          if (res_ch.ramp_distance !== want.ramp_dist)
            report_mismatch("ramp_distance", res_ch.ramp_distance, want.ramp_dist);
          if (res_ch.ramp_root !== want.root)
            report_mismatch("ramp_root", {16'd0, res_ch.ramp_root}, {16'd0, want.root});
          if (res_ch.step_delay !== want.delay)
            report_mismatch("step_delay", res_ch.step_delay, want.delay);
          if (res_ch.delay_changed !== want.changed)
            report_mismatch("delay_changed", {31'd0, res_ch.delay_changed},
                            {31'd0, want.changed});
          if (res_ch.speed_reached !== want.reached)
            report_mismatch("speed_reached", {31'd0, res_ch.speed_reached},
                            {31'd0, want.reached});
        end
      end
      tick_fired <= tick_ch.valid && tick_ch.ready;
      if (tick_ch.valid && tick_ch.ready) begin
        taken.remaining = tick_ch.remaining_distance;
        taken.new_move  = tick_ch.new_move;
        expected_results.push_back(regulate_tick(taken));
        accepted_total++;
      end
    end
  end

  // Tick driver: bursts of random length separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : drive_ticks
    tick_t nt;
    if (rst_ni && (!tick_ch.valid || tick_fired)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        tick_ch.valid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        nt = pending_ticks.pop_front();
        tick_ch.valid              <= 1'b1;
        tick_ch.remaining_distance <= nt.remaining;
        tick_ch.new_move           <= nt.new_move;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        tick_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: open, random or patterned stalls, plus one long hold-off.
  rx_mode_e    rx_mode   = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned rx_count  = 0;
  logic        long_hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_count <= rx_count + 1;
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 300) begin
        hold_left      <= LONG_HOLD;
        long_hold_done <= 1'b1;
        res_ch.ready   <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   <= rx_mode_e'($urandom_range(0, 2));
          mode_left <= $urandom_range(16, 96);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (rx_mode)
          RX_OPEN:   res_ch.ready <= 1'b1;
          RX_RANDOM: res_ch.ready <= ($urandom_range(0, 99) < 60);
          default:   res_ch.ready <= (rx_count % 7) >= 3;
        endcase
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_tick(input logic [31:0] remaining, input logic new_move);
    tick_t t;
    t.remaining = remaining;
    t.new_move  = new_move;
    pending_ticks.push_back(t);
    queued_total++;
  endtask

  // Block until every queued tick is taken and every result is back.
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || accepted_total != queued_total ||
           expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [srr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      srr_pkg::CFG_TARGET_DELAY: cfg_target = val;
      srr_pkg::CFG_DELAY_SCALE:  cfg_scale  = val;
      srr_pkg::CFG_RAMP_STEP:    cfg_step   = val[srr_pkg::STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_ramp(input logic [31:0] target, input logic [31:0] scale,
                          input logic [7:0] step);
    wait_drained();
    write_reg(srr_pkg::CFG_TARGET_DELAY, target);
    write_reg(srr_pkg::CFG_DELAY_SCALE, scale);
    write_reg(srr_pkg::CFG_RAMP_STEP, {24'd0, step});
  endtask

  // Mostly moves with a falling remaining distance; some noise and cut moves.
  task automatic add_moves(input int unsigned count, input bit with_long);
    int unsigned made;
    int unsigned len;
    int unsigned cut;
    int unsigned start;
    longint unsigned rem;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_tick(($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1000),
                   $urandom_range(0, 1));
        made++;
      end else begin
        if (with_long && $urandom_range(0, 3) == 0) begin
          len   = $urandom_range(250, 400);
          start = $urandom_range(600000, 1500000);
        end else begin
          len   = $urandom_range(6, 50);
          start = $urandom_range(50, 200000);
        end
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : len;
        for (int unsigned i = 0; i < cut && made < count; i++) begin
          rem = longint'(start) * (len - 1 - i) / (len - 1) +
                $urandom_range(0, start / (8 * len));
          queue_tick(rem[31:0], (i == 0) || ($urandom_range(0, 39) == 0));
          made++;
        end
      end
    end
  endtask

  initial begin
    rst_ni                     = 1'b0;
    cfg_we                     = 1'b0;
    cfg_index                  = srr_pkg::CFG_TARGET_DELAY;
    cfg_data                   = '0;
    tick_ch.valid              = 1'b0;
    tick_ch.remaining_distance = '0;
    tick_ch.new_move           = 1'b0;
    res_ch.ready               = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: an idle tick, then a move whose delay equals the target.
    queue_tick(32'd0, 1'b0);
    queue_tick(32'd0, 1'b1);

    // Fast ramp from standstill, then a drop to zero that clears the root.
    set_ramp(32'd1000, 32'hFFFF_FFFF, 8'd255);
    queue_tick(32'hFFFF_FFFF, 1'b1);
    repeat (3) queue_tick(32'hFFFF_FFFF, 1'b0);
    queue_tick(32'd0, 1'b0);
    queue_tick(32'hFFFF_FFFF, 1'b1);
    queue_tick(32'd254, 1'b0);

    // Unit steps through the exact squares, down across one, then to zero.
    set_ramp(32'd0, 32'd100, 8'd1);
    queue_tick(32'd0, 1'b0);
    queue_tick(32'hFFFF_FFFF, 1'b1);
    repeat (5) queue_tick(32'hFFFF_FFFF, 1'b0);
    queue_tick(32'd3, 1'b0);
    queue_tick(32'd0, 1'b0);

    // A zero ramp step only sets the direction flags.
    set_ramp(32'd0, 32'd100, 8'd0);
    queue_tick(32'hFFFF_FFFF, 1'b1);
    queue_tick(32'hFFFF_FFFF, 1'b0);

    // Endless acceleration with long moves, so that the jumps saturate.
    set_ramp(32'd0, 32'hFFFF_FFFF, 8'd255);
    add_moves(330, 1'b1);
    // Target reached from above and, after the large distance, from below.
    set_ramp(32'd20000, 32'd2000000, 8'd255);
    add_moves(160, 1'b0);
    set_ramp(32'hFFFF_FFFF, 32'd0, 8'd200);
    add_moves(120, 1'b0);
    set_ramp(32'd5000, 32'd30000, 8'd1);
    add_moves(150, 1'b0);
    set_ramp(32'd123, 32'd50000, 8'd0);
    add_moves(80, 1'b0);
    repeat (2) begin
      set_ramp($urandom_range(0, 100000), $urandom, $urandom_range(1, 255));
      add_moves(140, 1'b0);
    end

    wait_drained();
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
